[hw/rtl/sct_pkg.sv]
// Package for the shell command tokenizer: character classes, scanner states,
// token kinds, the result record and the byte classifier.
// Depends on nothing; used by shell_command_tokenizer.
package sct_pkg;

   // Width of the byte position counter and of the stored word start.
   localparam int POSITION_BITS = 16;
   // Width of a position as it leaves the block.
   localparam int OUT_POS_BITS  = 16;
   // Depth of the result queue; a byte may push two results.
   localparam int QUEUE_DEPTH   = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   typedef logic [POSITION_BITS-1:0] position_type;
   localparam position_type POS_MAX = '1;

   // Character constants.
   localparam logic [7:0] CH_AST = 8'h2A;  // '*'
   localparam logic [7:0] CH_LT  = 8'h3C;  // '<'
   localparam logic [7:0] CH_GT  = 8'h3E;  // '>'
   localparam logic [7:0] CH_BAR = 8'h7C;  // '|'
   localparam logic [7:0] CH_QUO = 8'h22;  // '"'
   localparam logic [7:0] CH_AMP = 8'h26;  // '&'
   localparam logic [7:0] CH_BSL = 8'h5C;  // backslash
   localparam logic [7:0] CH_TAB = 8'h09;  // tab
   localparam logic [7:0] CH_NL  = 8'h0A;  // newline
   localparam logic [7:0] CH_SP  = 8'h20;  // space
   localparam logic [7:0] CH_EOT = 8'h00;  // end of text
   localparam logic [7:0] CH_DASH  = 8'h2D;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_UNDER = 8'h5F;
   localparam logic [7:0] CH_DOT   = 8'h2E;

   typedef enum logic [3:0] {
      C_AST, C_LT, C_GT, C_NL, C_SP, C_EOT, C_BAR, C_ID, C_QUO, C_AMP,
      C_TAB, C_BSL, C_OTHER
   } char_class_type;

   typedef enum logic [2:0] {
      S_START = 3'd0,
      S_COM1  = 3'd1,
      S_COM2  = 3'd2,
      S_WORD  = 3'd3,
      S_Q1    = 3'd4,
      S_Q2    = 3'd5
   } scan_state_type;

   typedef enum logic [3:0] {
      K_COMMENT = 4'd0,
      K_IN      = 4'd1,
      K_OUT     = 4'd2,
      K_PIPE    = 4'd3,
      K_BG      = 4'd4,
      K_NL      = 4'd5,
      K_END     = 4'd6,
      K_WORD    = 4'd7,
      K_ERR     = 4'd8
   } token_kind_type;

   // One result as it waits in the queue.
   typedef struct packed {
      token_kind_type            kind;
      logic [OUT_POS_BITS-1:0]   word_start;
      logic [OUT_POS_BITS-1:0]   word_end;
      logic [OUT_POS_BITS-1:0]   position;
      logic                      last;
   } queue_entry_type;

   // Sort a byte into one of the thirteen lexer classes.
   function automatic char_class_type classify(input logic [7:0] b);
      char_class_type c;
      if (b == CH_AST)                       c = C_AST;
      else if (b == CH_LT)                   c = C_LT;
      else if (b == CH_GT)                   c = C_GT;
      else if (b == CH_NL)                   c = C_NL;
      else if (b == CH_SP)                   c = C_SP;
      else if (b == CH_EOT)                  c = C_EOT;
      else if (b == CH_BAR)                  c = C_BAR;
      else if ((b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
               (b >= 8'h61 && b <= 8'h7A) || b == CH_DASH ||
               b == CH_SLASH || b == CH_UNDER || b == CH_DOT)
                                             c = C_ID;
      else if (b == CH_QUO)                  c = C_QUO;
      else if (b == CH_AMP)                  c = C_AMP;
      else if (b == CH_TAB)                  c = C_TAB;
      else if (b == CH_BSL)                  c = C_BSL;
      else                                   c = C_OTHER;
      return c;
   endfunction

   // Position increment that sticks at the top value.
   function automatic position_type sat_inc(input position_type v);
      return (v == POS_MAX) ? v : position_type'(v + 1'b1);
   endfunction

endpackage

[hw/rtl/shell_command_tokenizer.sv]
// Shell command tokenizer: one byte per cycle into lexer tokens while
// req_tready is high. Each byte's tokens are written into the result queue
// when the byte is transferred and are offered on rsp from there; the result
// channel carries at most one token per cycle, so a byte yielding two tokens
// is absorbed by the four-entry result queue (req_tready needs two free entries).
// Reset (synchronous, active high) returns the scanner to start, clears the
// positions and empties the result queue.
// Depends on sct_pkg.
module shell_command_tokenizer
   import sct_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] byte_value
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [3:0] token_kind, [19:4] word_start,
                                    // [35:20] word_end, [51:36] token_position,
                                    // [55:52] zero
   output logic        rsp_tlast    // last_of_run
);

   scan_state_type state_ff, state_in;
   position_type   byte_pos_ff, byte_pos_in;
   position_type   word_begin_ff, word_begin_in;

   queue_entry_type queue_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0] count_ff, count_in;

   logic           req_fire;
   logic           rsp_fire;
   char_class_type cls;
   position_type   p;

   // First-phase decode of the current state.
   logic           again;
   logic           first_emit;
   token_kind_type first_kind;
   logic           first_word;

   // Second-phase (start state) handling.
   logic           second_emit;
   token_kind_type second_kind;
   logic           eot;

   queue_entry_type tok_a, tok_b;
   logic           push_a, push_b;

   assign req_fire = req_tvalid && req_tready;
   assign rsp_fire = rsp_tvalid && rsp_tready;
   assign cls      = classify(req_tdata);
   assign p        = byte_pos_ff;

   // Handling of the byte in the current state.
   always_comb begin
      again      = 1'b0;
      first_emit = 1'b0;
      first_kind = K_ERR;
      first_word = 1'b0;
      case (state_ff)
         S_COM1: begin
            if (cls != C_AST) first_emit = 1'b1;
         end
         S_COM2: begin
            if (cls == C_NL || cls == C_EOT) begin
               first_emit = 1'b1;
               first_kind = K_COMMENT;
               again      = 1'b1;
            end
         end
         S_WORD: begin
            if (cls == C_ID) begin
               first_emit = 1'b0;
            end else if (cls == C_AST || cls == C_QUO || cls == C_OTHER) begin
               first_emit = 1'b1;
            end else begin
               first_emit = 1'b1;
               first_kind = K_WORD;
               first_word = 1'b1;
               again      = 1'b1;
            end
         end
         S_Q1: begin
            if (cls != C_SP && cls != C_ID) first_emit = 1'b1;
         end
         S_Q2: begin
            if (cls == C_QUO) begin
               first_emit = 1'b1;
               first_kind = K_WORD;
               first_word = 1'b1;
            end else if (cls != C_SP && cls != C_ID) begin
               first_emit = 1'b1;
            end
         end
         default: again = 1'b1;
      endcase
   end

   // Handling of the byte again from the start state.
   always_comb begin
      second_emit = 1'b0;
      second_kind = K_ERR;
      eot         = 1'b0;
      if (again) begin
         case (cls)
            C_LT:  begin second_emit = 1'b1; second_kind = K_IN;   end
            C_GT:  begin second_emit = 1'b1; second_kind = K_OUT;  end
            C_BAR: begin second_emit = 1'b1; second_kind = K_PIPE; end
            C_AMP: begin second_emit = 1'b1; second_kind = K_BG;   end
            C_BSL: begin second_emit = 1'b1; second_kind = K_NL;   end
            C_EOT: begin
               second_emit = 1'b1;
               second_kind = K_END;
               eot         = 1'b1;
            end
            C_AST, C_NL, C_SP, C_TAB, C_ID, C_QUO: second_emit = 1'b0;
            default: second_emit = 1'b1;
         endcase
      end
   end

   // Next scanner state and positions.
   always_comb begin
      state_in      = state_ff;
      word_begin_in = word_begin_ff;
      byte_pos_in   = byte_pos_ff;
      if (req_fire) begin
         case (state_ff)
            S_COM1:  state_in = (cls == C_AST) ? S_COM2 : S_START;
            S_COM2:  state_in = again ? S_START : S_COM2;
            S_WORD:  state_in = (cls == C_ID) ? S_WORD : S_START;
            S_Q1: begin
               if (cls == C_SP)      state_in = S_Q1;
               else if (cls == C_ID) state_in = S_Q2;
               else                  state_in = S_START;
            end
            S_Q2:    state_in = (cls == C_SP || cls == C_ID) ? S_Q2 : S_START;
            default: state_in = S_START;
         endcase
         if (again) begin
            case (cls)
               C_AST: state_in = S_COM1;
               C_ID: begin
                  state_in      = S_WORD;
                  word_begin_in = p;
               end
               C_QUO: begin
                  state_in      = S_Q1;
                  word_begin_in = sat_inc(p);
               end
               default: state_in = S_START;
            endcase
         end
         byte_pos_in = eot ? '0 : sat_inc(p);
      end
   end

   // Assemble the one or two result records for this byte.
   always_comb begin
      queue_entry_type t1, t2;
      t1.kind       = first_kind;
      t1.word_start = first_word ? OUT_POS_BITS'(word_begin_ff) : '0;
      t1.word_end   = first_word ? OUT_POS_BITS'(p) : '0;
      t1.position   = OUT_POS_BITS'(p);
      t1.last       = !second_emit;
      t2.kind       = second_kind;
      t2.word_start = '0;
      t2.word_end   = '0;
      t2.position   = OUT_POS_BITS'(p);
      t2.last       = 1'b1;
      if (first_emit) begin
         tok_a = t1;
         tok_b = t2;
      end else begin
         tok_a = t2;
         tok_b = t2;
      end
      push_a = req_fire && (first_emit || second_emit);
      push_b = req_fire && first_emit && second_emit;
   end

   // Queue pointers and fill level.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      if (push_b)      wr_ptr_in = wr_ptr_ff + QUEUE_PTR_BITS'(2);
      else if (push_a) wr_ptr_in = wr_ptr_ff + QUEUE_PTR_BITS'(1);
      rd_ptr_in = rsp_fire ? rd_ptr_ff + QUEUE_PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff + QUEUE_CNT_BITS'(push_a) + QUEUE_CNT_BITS'(push_b)
                  - QUEUE_CNT_BITS'(rsp_fire);
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_START;
         byte_pos_ff   <= '0;
         word_begin_ff <= '0;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         count_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         byte_pos_ff   <= byte_pos_in;
         word_begin_ff <= word_begin_in;
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         count_ff      <= count_in;
      end
   end

   // Result queue storage; a byte may write two consecutive entries.
   always_ff @(posedge clock) begin
      if (push_a) queue_ff[wr_ptr_ff] <= tok_a;
      if (push_b) queue_ff[wr_ptr_ff + QUEUE_PTR_BITS'(1)] <= tok_b;
   end

   // Port drive.
   assign req_tready = (count_ff <= QUEUE_CNT_BITS'(QUEUE_DEPTH - 2));
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tdata  = {4'b0000, queue_ff[rd_ptr_ff].position,
                        queue_ff[rd_ptr_ff].word_end,
                        queue_ff[rd_ptr_ff].word_start,
                        queue_ff[rd_ptr_ff].kind};
   assign rsp_tlast  = queue_ff[rd_ptr_ff].last;

`ifndef SYNTHESIS
   // The queue never holds more than its depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_CNT_BITS'(QUEUE_DEPTH))
      else $error("result queue overfilled");

   // A byte transfer always finds room for two results.
   a_room_on_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> count_ff <= QUEUE_CNT_BITS'(QUEUE_DEPTH - 2))
      else $error("byte accepted without room for two results");

   // The fill level holds still when nothing is pushed or popped.
   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (!push_a && !rsp_fire) |=> count_ff == $past(count_ff))
      else $error("queue fill level changed without a transfer");

   // Entering a plain word records the position of its first byte.
   a_word_begin: assert property (@(posedge clock) disable iff (reset)
      (req_fire && state_ff != S_WORD && state_in == S_WORD)
      |=> word_begin_ff == $past(byte_pos_ff))
      else $error("word start not captured on entry to word state");
`endif

endmodule
